// ===== hdl/emgenv_pkg.sv =====
// Shared types, widths and constants of the EMG envelope to servo block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package emgenv_pkg;

    // Moving-average window; the baseline divide is a shift, so the depth is a power of two.
    localparam int WINDOW_DEPTH = 128;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

    // Field widths.
    localparam int SMP_W  = 10;
    localparam int SUM_W  = SMP_W + WIN_AW;
    localparam int Q_W    = 15;
    localparam int TICK_W = 16;
    localparam int PROD_W = 2 * Q_W + 1;
    localparam int MAP_W  = SMP_W + TICK_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENVELOPE_ALPHA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX       = 3'd4;

    // Register reset values.
    localparam logic [Q_W-1:0]    ALPHA_RESET    = 15'd107;
    localparam logic [SMP_W-1:0]  SAT_LOW_RESET  = 10'd10;
    localparam logic [SMP_W-1:0]  SAT_HIGH_RESET = 10'd1013;
    localparam logic [TICK_W-1:0] MIN_RESET      = 16'd2000;
    localparam logic [TICK_W-1:0] MAX_RESET      = 16'd4000;

    // Fixed-point constants.
    localparam logic [SMP_W-1:0]  MID_SAMPLE     = 10'd512;
    localparam logic [SUM_W-1:0]  SUM_RESET      = SUM_W'(512 * WINDOW_DEPTH);
    localparam logic [Q_W-1:0]    Q15_MAX        = {Q_W{1'b1}};
    localparam logic [Q_W:0]      Q15_UNIT       = 16'd32768;
    localparam logic [PROD_W-1:0] Q15_ROUND      = PROD_W'(1 << 14);
    localparam int                RECT_SHIFT     = 5;
    localparam logic [SMP_W:0]    ENV_FULL_SCALE = 11'd1023;

    // Configuration register set.
    typedef struct packed {
        logic [Q_W-1:0]    envelope_alpha;
        logic [SMP_W-1:0]  saturation_low;
        logic [SMP_W-1:0]  saturation_high;
        logic [TICK_W-1:0] pulse_min;
        logic [TICK_W-1:0] pulse_max;
    } t_cfg;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic take_in;   // input transfer: capture fields, read window memory
        logic upd;       // update window and sum, feedback multiply
        logic mul;       // baseline, rectify, input multiply
        logic acc;       // filter accumulate
        logic map;       // span multiply
        logic div;       // divide by full scale
        logic out_load;  // load the result register
    } t_cmd;

endpackage

// ===== hdl/emgenv_ctrl.sv =====
// Sequencer of the EMG envelope block: input and output handshakes and the step commands.
// Depends on emgenv_pkg.
`timescale 1ns / 1ps

module emgenv_ctrl
    import emgenv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_MUL,
        S_ACC,
        S_MAP,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    logic   r_out_valid, n_out_valid;
    logic   w_load;

    // The result register is free when empty or when its result leaves this cycle.
    assign w_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Next state and output-valid tracking.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid && r_in_ready) n_state = S_UPD;
            S_UPD:   n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = S_MAP;
            S_MAP:   n_state = S_DIV;
            S_DIV:   n_state = S_OUT;
            S_OUT:   if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // State and registered handshake outputs; the input stays closed during reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == S_IDLE);
            r_out_valid <= n_out_valid;
        end
    end

    // Step commands decoded from the state.
    always_comb begin
        o_cmd          = '0;
        o_cmd.take_in  = (r_state == S_IDLE) && i_in_valid && r_in_ready;
        o_cmd.upd      = (r_state == S_UPD);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.acc      = (r_state == S_ACC);
        o_cmd.map      = (r_state == S_MAP);
        o_cmd.div      = (r_state == S_DIV);
        o_cmd.out_load = w_load;
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/emgenv_dp.sv =====
// Datapath of the EMG envelope block: window memory, running sum, Q15 filter and servo mapping.
// Depends on emgenv_pkg; steps are driven by emgenv_ctrl.
`timescale 1ns / 1ps

module emgenv_dp
    import emgenv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_cfg              i_cfg,
    input  logic [SMP_W-1:0]  i_adc_sample,
    input  logic              i_stop_pin_n,
    output logic [SMP_W-1:0]  o_envelope,
    output logic [TICK_W-1:0] o_servo_ticks,
    output logic              o_clipped,
    output logic              o_stop_active
);

    // Rounded Q15 product to the 0..32767 range.
    function automatic logic [Q_W-1:0] q15_sat(input logic [PROD_W-1:0] p);
        logic [PROD_W-Q_W-1:0] hi;
        hi = p[PROD_W-1:Q_W];
        return (hi > {1'b0, Q15_MAX}) ? Q15_MAX : hi[Q_W-1:0];
    endfunction

    // Window storage; an entry not yet written reads as mid-scale.
    logic [SMP_W-1:0]        r_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] r_vld;
    logic [SMP_W-1:0]        r_rd;
    logic                    r_rd_vld;
    logic [WIN_AW-1:0]       r_ptr;
    logic [SUM_W-1:0]        r_sum;

    // Per-item registers.
    logic [SMP_W-1:0]  r_smp;
    logic              r_stop;
    logic              r_clip;
    logic [PROD_W-1:0] r_p1;
    logic [PROD_W-1:0] r_p2;
    logic [Q_W-1:0]    r_fm;
    logic [MAP_W-1:0]  r_prod;
    logic [TICK_W-1:0] r_scaled;

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_rd <= r_mem[r_ptr];
        end
        if (i_cmd.upd) begin
            r_mem[r_ptr] <= r_smp;
        end
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_smp <= i_adc_sample;
            r_stop <= !i_stop_pin_n;
        end
    end

    // Window update: the sum drops the oldest entry and adds the new sample.
    logic [SMP_W-1:0] w_old;
    logic [SUM_W-1:0] n_sum;
    logic [Q_W:0]     w_unit;

    assign w_old  = r_rd_vld ? r_rd : MID_SAMPLE;
    assign n_sum  = r_sum - SUM_W'(w_old) + SUM_W'(r_smp);
    assign w_unit = Q15_UNIT - {1'b0, i_cfg.envelope_alpha};

    // Baseline, rectification and clip test.
    logic [SMP_W-1:0] w_base;
    logic [SMP_W-1:0] w_rect;
    logic             w_clip;
    logic [Q_W-1:0]   w_x;

    assign w_base = r_sum[SUM_W-1:WIN_AW];
    assign w_rect = (r_smp >= w_base) ? (r_smp - w_base) : (w_base - r_smp);
    assign w_clip = (r_smp <= i_cfg.saturation_low) || (r_smp >= i_cfg.saturation_high);
    assign w_x    = w_clip ? '0 : {w_rect, {RECT_SHIFT{1'b0}}};

    // Filter accumulate with saturation.
    logic [Q_W:0] w_acc;

    assign w_acc = {1'b0, q15_sat(r_p1)} + {1'b0, q15_sat(r_p2)};

    // Division of the mapped product by 1023, using 1023 = 1024 - 1.
    logic [TICK_W-1:0] w_q0;
    logic [TICK_W:0]   w_r0;
    logic [6:0]        w_q1;
    logic [SMP_W:0]    w_r1;
    logic [TICK_W-1:0] w_q;

    assign w_q0 = r_prod[MAP_W-1:SMP_W];
    assign w_r0 = {{(TICK_W+1-SMP_W){1'b0}}, r_prod[SMP_W-1:0]} + {1'b0, w_q0};
    assign w_q1 = w_r0[TICK_W:SMP_W];
    assign w_r1 = {1'b0, w_r0[SMP_W-1:0]} + {{(SMP_W+1-7){1'b0}}, w_q1};
    assign w_q  = w_q0 + TICK_W'(w_q1) + TICK_W'(w_r1 >= ENV_FULL_SCALE);

    // Servo mapping, clamps and the centre value on stop.
    logic              w_span_ok;
    logic [TICK_W-1:0] w_span;
    logic [TICK_W:0]   w_mid;
    logic [TICK_W-1:0] w_ticks;

    assign w_span_ok = i_cfg.pulse_max > i_cfg.pulse_min;
    assign w_span    = w_span_ok ? (i_cfg.pulse_max - i_cfg.pulse_min) : '0;
    assign w_mid     = {1'b0, i_cfg.pulse_min} + {1'b0, i_cfg.pulse_max};

    always_comb begin
        if (r_stop) begin
            w_ticks = w_mid[TICK_W:1];
        end else if (w_span_ok) begin
            w_ticks = i_cfg.pulse_min + r_scaled;
        end else begin
            w_ticks = i_cfg.pulse_max;
        end
    end

    // Persistent window and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ptr <= '0;
            r_sum <= SUM_RESET;
            r_fm  <= '0;
        end else begin
            if (i_cmd.upd) begin
                r_vld[r_ptr] <= 1'b1;
                r_ptr        <= r_ptr + 1'b1;
                r_sum        <= n_sum;
            end
            if (i_cmd.acc) begin
                r_fm <= (w_acc > {1'b0, Q15_MAX}) ? Q15_MAX : w_acc[Q_W-1:0];
            end
        end
    end

    // Step registers of the arithmetic.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_rd_vld <= r_vld[r_ptr];
        end
        if (i_cmd.upd) begin
            r_p2 <= w_unit * r_fm + Q15_ROUND;
        end
        if (i_cmd.mul) begin
            r_p1   <= i_cfg.envelope_alpha * w_x + Q15_ROUND;
            r_clip <= w_clip;
        end
        if (i_cmd.map) begin
            r_prod <= r_fm[Q_W-1:RECT_SHIFT] * w_span;
        end
        if (i_cmd.div) begin
            r_scaled <= w_q;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_envelope    <= r_fm[Q_W-1:RECT_SHIFT];
            o_servo_ticks <= w_ticks;
            o_clipped     <= r_clip;
            o_stop_active <= r_stop;
        end
    end

endmodule

// ===== hdl/emg_envelope_to_servo_top.sv =====
// Top level of the EMG envelope to servo block: configuration registers and the two submodules.
// Depends on emgenv_pkg, emgenv_ctrl and emgenv_dp.
`timescale 1ns / 1ps

// Usage:
// One converter sample and the stop pin level enter per transfer on the input channel
// (i_in_valid / o_in_ready); one result leaves per sample on the output channel
// (o_out_valid / i_out_ready) with the envelope, servo ticks, clip flag and stop flag.
// Registers are written through the configuration channel (i_cfg_valid / o_cfg_ready,
// i_cfg_index, i_cfg_data), which is always ready; indexes beyond the list are ignored.
// Write them only while no sample is in flight.
// The sequencer takes a new sample only after the last result is loaded. It walks each
// sample through the window memory read, window update with feedback multiply, input
// multiply, filter accumulate, span multiply, divide by full scale and result load.
// A new sample is accepted while an earlier result still waits in the output register.
// If the receiver stalls, the next result waits in its last step and o_in_ready stays low
// until the output register frees up.
// Reset (synchronous, active low) returns the registers to their defaults, the window to
// mid-scale, the filter to zero and empties the output register; no clearing pass is needed.

module emg_envelope_to_servo_top
    import emgenv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SMP_W-1:0]      i_adc_sample,
    input  logic                  i_stop_pin_n,
    // Output channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SMP_W-1:0]      o_envelope,
    output logic [TICK_W-1:0]     o_servo_ticks,
    output logic                  o_clipped,
    output logic                  o_stop_active,
    // Configuration channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.envelope_alpha  <= ALPHA_RESET;
            r_cfg.saturation_low  <= SAT_LOW_RESET;
            r_cfg.saturation_high <= SAT_HIGH_RESET;
            r_cfg.pulse_min       <= MIN_RESET;
            r_cfg.pulse_max       <= MAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ENVELOPE_ALPHA:  r_cfg.envelope_alpha  <= i_cfg_data[Q_W-1:0];
                CFG_SATURATION_LOW:  r_cfg.saturation_low  <= i_cfg_data[SMP_W-1:0];
                CFG_SATURATION_HIGH: r_cfg.saturation_high <= i_cfg_data[SMP_W-1:0];
                CFG_PULSE_MIN:       r_cfg.pulse_min       <= i_cfg_data[TICK_W-1:0];
                CFG_PULSE_MAX:       r_cfg.pulse_max       <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    emgenv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and storage.
    emgenv_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg         (r_cfg),
        .i_adc_sample  (i_adc_sample),
        .i_stop_pin_n  (i_stop_pin_n),
        .o_envelope    (o_envelope),
        .o_servo_ticks (o_servo_ticks),
        .o_clipped     (o_clipped),
        .o_stop_active (o_stop_active)
    );

    // Only one sample is in flight: the input closes right after a transfer.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a sample is still in flight");

    // A new result appears only at the end of a sample's processing.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result produced without a sample in flight");

    // No new result appears in the cycle right after an input transfer.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid || !$rose(o_out_valid))
        else $error("result appeared right after an input transfer");

endmodule
